/* rtl/deq_pkg.sv */
// shared types and constants for the double-ended queue unit
// opcodes, status codes, controller states and the per-cell command bundle
// no dependencies

package deq_pkg;

   // operation codes carried by an input transaction
   localparam logic [2:0] OP_QUERY      = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_POP_BACK   = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;

   typedef enum logic {
      STATE_IDLE,
      STATE_WAIT
   } state_type;

   // one-cycle command broadcast to every cell, already gated by full/empty
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
      logic clear;
   } cell_cmd_type;

endpackage

/* rtl/deq_cell.sv */
// one storage cell of the queue chain: an element and its occupied flag
// shifts toward either neighbor on front operations; uses deq_pkg

module deq_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_pkg::cell_cmd_type cmd,
   input  logic [DATA_WIDTH-1:0] push_data,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic                  left_occ,
   input  logic [DATA_WIDTH-1:0] right_data,
   input  logic                  right_occ,
   output logic [DATA_WIDTH-1:0] data_out,
   output logic                  occ_out,
   output logic [DATA_WIDTH-1:0] tap_out
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  occ_ff, occ_in;
   logic                  first_free;
   logic                  is_last;

   assign first_free = !occ_ff && left_occ;
   assign is_last    = occ_ff && !right_occ;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      if (cmd.clear) begin
         occ_in = 1'b0;
      end else if (cmd.push_front) begin
         data_in = left_data;
         occ_in  = left_occ;
      end else if (cmd.pop_front) begin
         data_in = right_data;
         occ_in  = right_occ;
      end else if (cmd.push_back && first_free) begin
         data_in = push_data;
         occ_in  = 1'b1;
      end else if (cmd.pop_back && is_last) begin
         occ_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign occ_out  = occ_ff;
   assign tap_out  = data_ff & {DATA_WIDTH{is_last}};

endmodule

/* rtl/deq_or_tree.sv */
// registered or-reduction tree, fan-in of eight per level
// picks the single non-zero back-element tap out of the cell chain; no dependencies

module deq_or_tree #(
   parameter int LEAVES = 64,
   parameter int WIDTH  = 32
) (
   input  logic                    clock,
   input  logic [LEAVES*WIDTH-1:0] leaves,
   output logic [WIDTH-1:0]        result
);

   localparam int GROUPS = (LEAVES + 7) / 8;

   logic [GROUPS*8*WIDTH-1:0] padded;
   logic [GROUPS*WIDTH-1:0]   grp_in, grp_ff;

   assign padded = (GROUPS*8*WIDTH)'(leaves);

   always_comb begin
      grp_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         for (int j = 0; j < 8; j++) begin
            grp_in[g*WIDTH +: WIDTH] = grp_in[g*WIDTH +: WIDTH]
                                       | padded[(g*8+j)*WIDTH +: WIDTH];
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   generate
      if (GROUPS > 1) begin : g_next
         deq_or_tree #(
            .LEAVES (GROUPS),
            .WIDTH  (WIDTH)
         ) u_next (
            .clock  (clock),
            .leaves (grp_ff),
            .result (result)
         );
      end else begin : g_root
         assign result = grp_ff[WIDTH-1:0];
      end
   endgenerate

endmodule

/* rtl/double_ended_queue_unit.sv */
// top level of the double-ended queue unit: controller, cell chain, back-value tree
// depends on deq_pkg, deq_cell and deq_or_tree
//
// usage
//   req channel: one transaction per operation, opcode and push value in req_tdata
//   rsp channel: exactly one transaction per request, carrying status, front and
//     back values after the operation, element count and an empty flag
//   storage is a chain of DEPTH cells; cell 0 always holds the front element and
//     occupied cells form a contiguous run from cell 0
//   push front / pop front shift the whole chain by one cell at the accept edge;
//     push back fills the first free cell, pop back frees the last occupied one
//   the back value is picked by a registered or-tree with fan-in eight, which
//     sets the latency: TREE_LEVELS = ceil(log8(DEPTH)) stages, at least 1 (2 for DEPTH 64)
//   a response is loaded once the tree has settled; no new request is taken
//     until the response to the previous one has been loaded into the output register
//   reset: queue empty, no response pending; stored element values are not cleared
//   rsp stall: the response sits in the output register while the next request
//     is taken and processed; that result is held back until the register frees
//   pops on an empty queue report underflow, pushes on a full queue report overflow;
//     opcodes beyond clear behave as a query

module double_ended_queue_unit #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode[2:0], push_value[34:3], zero fill
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // status[1:0], front_value[33:2], back_value[65:34],
                                    // element_count[72:66], is_empty[73], zero fill
);

   function automatic int tree_levels(input int n);
      int levels;
      int left;
      levels = 0;
      left   = n;
      for (int i = 0; i < 8; i++) begin
         if (left > 1 || levels == 0) begin
            left   = (left + 7) / 8;
            levels = levels + 1;
         end
      end
      return levels;
   endfunction

   localparam int TREE_LEVELS = tree_levels(DEPTH);
   localparam int CW          = $clog2(DEPTH + 1);
   localparam int WW          = $clog2(TREE_LEVELS + 1);

   // request fields
   logic [2:0]            req_opcode;
   logic [31:0]           req_push_value;
   logic [DATA_WIDTH-1:0] push_data;

   assign req_opcode     = req_tdata[2:0];
   assign req_push_value = req_tdata[34:3];
   assign push_data      = DATA_WIDTH'(req_push_value);

   // controller state
   deq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [WW-1:0]      wait_ff, wait_in;
   logic [1:0]         pend_status_ff, pend_status_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [79:0] rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  load_rsp;
   logic                  full;
   logic                  empty;
   deq_pkg::cell_cmd_type cmd;
   logic [1:0]            op_status;

   // cell chain wiring
   logic [DATA_WIDTH-1:0]       cell_data [DEPTH];
   logic [DEPTH-1:0]            cell_occ;
   logic [DEPTH*DATA_WIDTH-1:0] taps;
   logic [DATA_WIDTH-1:0]       back_data;
   logic [31:0]                 front_value;
   logic [31:0]                 back_value;

   assign req_accept = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);

   // decode the operation into a gated chain command and a status
   always_comb begin
      cmd       = '0;
      op_status = deq_pkg::ST_OK;
      count_in  = count_ff;
      case (req_opcode)
         deq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               op_status = deq_pkg::ST_OVERFLOW;
            end else begin
               cmd.push_front = req_accept;
               count_in       = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               op_status = deq_pkg::ST_OVERFLOW;
            end else begin
               cmd.push_back = req_accept;
               count_in      = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               op_status = deq_pkg::ST_UNDERFLOW;
            end else begin
               cmd.pop_front = req_accept;
               count_in      = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (empty) begin
               op_status = deq_pkg::ST_UNDERFLOW;
            end else begin
               cmd.pop_back = req_accept;
               count_in     = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_CLEAR: begin
            cmd.clear = req_accept;
            count_in  = '0;
         end
         default: begin
            // query and unused codes leave the queue alone
         end
      endcase
      if (!req_accept) begin
         count_in = count_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         deq_pkg::STATE_IDLE: begin
            if (req_accept) begin
               state_in = deq_pkg::STATE_WAIT;
            end
         end
         deq_pkg::STATE_WAIT: begin
            if (load_rsp) begin
               state_in = deq_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = deq_pkg::STATE_IDLE;
         end
      endcase
   end

   // controller outputs
   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         deq_pkg::STATE_IDLE: begin
            req_tready = 1'b1;
         end
         deq_pkg::STATE_WAIT: begin
            load_rsp = (wait_ff == '0) && (!rsp_valid_ff || rsp_tready);
         end
         default: begin
         end
      endcase
   end

   // tree drain counter and pending status
   // the chain settles at the accept edge, then each tree level adds a register
   always_comb begin
      wait_in        = wait_ff;
      pend_status_in = pend_status_ff;
      if (req_accept) begin
         wait_in        = WW'(TREE_LEVELS);
         pend_status_in = op_status;
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - 1'b1;
      end
   end

   // result fields, read once the tree has settled
   assign front_value = cell_occ[0] ? 32'(cell_data[0]) : '0;
   assign back_value  = 32'(back_data);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, empty, 7'(count_ff), back_value, front_value,
                         pend_status_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::STATE_IDLE;
         count_ff     <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // chain of cells, cell 0 at the front; ends tied off
   generate
      for (genvar k = 0; k < DEPTH; k++) begin : g_cell
         logic [DATA_WIDTH-1:0] left_data, right_data;
         logic                  left_occ, right_occ;

         if (k == 0) begin : g_head
            assign left_data = push_data;
            assign left_occ  = 1'b1;
         end else begin : g_mid_left
            assign left_data = cell_data[k-1];
            assign left_occ  = cell_occ[k-1];
         end

         if (k == DEPTH - 1) begin : g_tail
            assign right_data = '0;
            assign right_occ  = 1'b0;
         end else begin : g_mid_right
            assign right_data = cell_data[k+1];
            assign right_occ  = cell_occ[k+1];
         end

         deq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .push_data  (push_data),
            .left_data  (left_data),
            .left_occ   (left_occ),
            .right_data (right_data),
            .right_occ  (right_occ),
            .data_out   (cell_data[k]),
            .occ_out    (cell_occ[k]),
            .tap_out    (taps[k*DATA_WIDTH +: DATA_WIDTH])
         );
      end
   endgenerate

   // only the last occupied cell drives a non-zero tap
   deq_or_tree #(
      .LEAVES (DEPTH),
      .WIDTH  (DATA_WIDTH)
   ) u_back_tree (
      .clock  (clock),
      .leaves (taps),
      .result (back_data)
   );

   // occupied cells always form a run from the front whose length is the count
   a_occ_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_occ) == 32'(count_ff))
      else $error("cell occupancy does not match element count");

   a_occ_prefix: assert property (@(posedge clock) disable iff (reset)
      (cell_occ[0] == (count_ff != '0)))
      else $error("front cell occupancy disagrees with count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count above depth");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request taken while previous one still in flight");

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before it was taken");

endmodule

/* sim/tb_top.sv */
// self-checking testbench for double_ended_queue_unit
// a shadow deque predicts every response; directed corner cases, then random fill/drain/mixed/clear runs
// depends on deq_pkg and the rtl of double_ended_queue_unit

module tb_top;

   localparam int QUEUE_DEPTH = 64;

   // opcodes past clear, which the block treats as a query
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] front_value;
      logic [31:0] back_value;
      logic [6:0]  element_count;
      logic        is_empty;
   } outcome_type;

   // shadow copy of the deque plus the responses it still owes
   class deque_shadow;
      logic [31:0] slots [QUEUE_DEPTH];
      logic [5:0]  head;
      logic [6:0]  count;
      outcome_type pending_outcomes[$];
      int unsigned failures;

      function new();
         head = '0;
         count = '0;
         failures = 0;
      endfunction

      function int unsigned level();
         return count;
      endfunction

      // apply one accepted request and queue the response it must produce
      function void apply_operation(logic [2:0] op, logic [31:0] value);
         outcome_type outcome;
         logic [5:0]  slot;
         outcome = '0;
         outcome.status = deq_pkg::ST_OK;
         case (op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
               if (count == QUEUE_DEPTH) begin
                  outcome.status = deq_pkg::ST_OVERFLOW;
               end else if (op == deq_pkg::OP_PUSH_FRONT) begin
                  head = head - 6'd1;
                  slots[head] = value;
                  count = count + 7'd1;
               end else begin
                  slot = head + count[5:0];
                  slots[slot] = value;
                  count = count + 7'd1;
               end
            end
            deq_pkg::OP_POP_FRONT: begin
               if (count == 0) begin
                  outcome.status = deq_pkg::ST_UNDERFLOW;
               end else begin
                  head = head + 6'd1;
                  count = count - 7'd1;
               end
            end
            deq_pkg::OP_POP_BACK: begin
               if (count == 0) outcome.status = deq_pkg::ST_UNDERFLOW;
               else count = count - 7'd1;
            end
            deq_pkg::OP_CLEAR: begin
               head = '0;
               count = '0;
            end
            default: ;
         endcase
         if (count != 0) begin
            // a full ring has count[5:0] == 0, so the back slot wraps to head - 1
            slot = head + count[5:0] - 6'd1;
            outcome.front_value = slots[head];
            outcome.back_value = slots[slot];
         end
         outcome.element_count = count;
         outcome.is_empty = (count == 0);
         pending_outcomes.push_back(outcome);
      endfunction

      // compare one accepted response with the oldest outstanding prediction
      function void compare_outcome(logic [79:0] word);
         outcome_type want;
         outcome_type got;
         if (pending_outcomes.size() == 0) begin
            $error("response with nothing outstanding: %h", word);
            failures++;
            return;
         end
         want = pending_outcomes.pop_front();
         got.status = word[1:0];
         got.front_value = word[33:2];
         got.back_value = word[65:34];
         got.element_count = word[72:66];
         got.is_empty = word[73];
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.front_value !== want.front_value) begin
            $error("front_value: expected %h, got %h", want.front_value, got.front_value);
            failures++;
         end
         if (got.back_value !== want.back_value) begin
            $error("back_value: expected %h, got %h", want.back_value, got.back_value);
            failures++;
         end
         if (got.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want.element_count, got.element_count);
            failures++;
         end
         if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // opcode[2:0], push_value[34:3], zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // status, front, back, count, empty, zero fill

   deque_shadow shadow = new();
   bit          gaps_allowed = 1'b1;
   int unsigned stall_left = 0;
   int unsigned requests_sent = 0;

   double_ended_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // observe both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) shadow.apply_operation(req_tdata[2:0], req_tdata[34:3]);
         if (rsp_tvalid && rsp_tready) shadow.compare_outcome(rsp_tdata);
      end
   end

   // response back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (gaps_allowed && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // present one request, maybe after an idle burst, and wait until it is taken
   task automatic send_operation(input logic [2:0] op, input logic [31:0] value);
      if (gaps_allowed && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, value, op};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      @(negedge clock);
   endtask

   initial begin
      int unsigned kind;
      int unsigned roll;
      int unsigned drain_wait;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty-queue pops, field extremes, head wrap, spare opcodes, clear
      send_operation(deq_pkg::OP_QUERY, 32'h0000_0000);
      send_operation(deq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
      send_operation(deq_pkg::OP_POP_BACK, 32'h0000_0000);
      send_operation(deq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
      send_operation(deq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
      send_operation(deq_pkg::OP_PUSH_BACK, 32'hA5A5_A5A5);
      send_operation(deq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A);
      send_operation(deq_pkg::OP_QUERY, 32'hFFFF_FFFF);
      send_operation(OP_SPARE_LO, 32'hDEAD_BEEF);
      send_operation(OP_SPARE_HI, 32'hFFFF_FFFF);
      send_operation(deq_pkg::OP_POP_FRONT, 32'h1234_5678);
      send_operation(deq_pkg::OP_POP_BACK, 32'h0000_0000);
      send_operation(deq_pkg::OP_POP_FRONT, 32'h0000_0000);
      send_operation(deq_pkg::OP_POP_BACK, 32'h0000_0000);
      send_operation(deq_pkg::OP_POP_BACK, 32'h0000_0000);
      send_operation(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
      send_operation(deq_pkg::OP_POP_BACK, 32'h0000_0000);
      send_operation(deq_pkg::OP_PUSH_BACK, 32'h0000_0001);
      send_operation(deq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
      send_operation(deq_pkg::OP_CLEAR, 32'hFFFF_FFFF);
      send_operation(deq_pkg::OP_QUERY, 32'h0000_0000);
      send_operation(deq_pkg::OP_POP_FRONT, 32'h0000_0000);
      send_operation(deq_pkg::OP_PUSH_BACK, 32'h1234_5678);
      send_operation(deq_pkg::OP_CLEAR, 32'h0000_0000);

      // random runs: fill to overflow, drain to underflow, mixed traffic, clears
      while (requests_sent < 830) begin
         if (requests_sent >= 740) gaps_allowed = 1'b0;
         else gaps_allowed = ($urandom_range(0, 4) != 0);
         kind = $urandom_range(0, 9);
         if (kind <= 2) begin
            while (shadow.level() < QUEUE_DEPTH) begin
               roll = $urandom_range(0, 99);
               if (roll < 8)
                  send_operation(roll[0] ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
                                 $urandom());
               else if (roll < 10) send_operation(deq_pkg::OP_QUERY, $urandom());
               else
                  send_operation(roll[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                                 $urandom());
            end
            repeat ($urandom_range(1, 3))
               send_operation($urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT
                                                   : deq_pkg::OP_PUSH_BACK, $urandom());
         end else if (kind <= 5) begin
            while (shadow.level() > 0) begin
               roll = $urandom_range(0, 99);
               if (roll < 10)
                  send_operation(roll[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                                 $urandom());
               else
                  send_operation(roll[0] ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
                                 $urandom());
            end
            repeat ($urandom_range(1, 2))
               send_operation($urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT
                                                   : deq_pkg::OP_POP_BACK, $urandom());
         end else if (kind <= 8) begin
            repeat ($urandom_range(5, 40)) begin
               roll = $urandom_range(0, 99);
               if (roll < 30) send_operation(deq_pkg::OP_PUSH_FRONT, $urandom());
               else if (roll < 60) send_operation(deq_pkg::OP_PUSH_BACK, $urandom());
               else if (roll < 75) send_operation(deq_pkg::OP_POP_FRONT, $urandom());
               else if (roll < 90) send_operation(deq_pkg::OP_POP_BACK, $urandom());
               else if (roll < 95) send_operation(deq_pkg::OP_QUERY, $urandom());
               else if (roll < 97) send_operation(deq_pkg::OP_CLEAR, $urandom());
               else send_operation(roll[0] ? OP_SPARE_LO : OP_SPARE_HI, $urandom());
            end
         end else begin
            send_operation(deq_pkg::OP_CLEAR, $urandom());
            send_operation($urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT
                                                : deq_pkg::OP_POP_BACK, $urandom());
         end
      end
      req_tvalid <= 1'b0;

      // let outstanding responses drain, then keep waiting so that strays are caught
      drain_wait = 0;
      while (shadow.pending_outcomes.size() != 0 && drain_wait < 5000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (12) @(posedge clock);
      if (shadow.pending_outcomes.size() != 0)
         $error("%0d responses never arrived", shadow.pending_outcomes.size());

      if (shadow.failures == 0 && shadow.pending_outcomes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
